/* rtl/bnr_pkg.sv */
`default_nettype none

package bnr_pkg;

   localparam int MAX_CHANNELS = 64;
   localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // Queue between the front and the back.
   localparam int QDEPTH = 4;
   localparam int QAW = $clog2(QDEPTH);
   localparam int QLW = $clog2(QDEPTH + 1);

   // Configuration register indexes.
   localparam logic [2:0] REG_LAYOUT      = 3'd0;
   localparam logic [2:0] REG_RELU_ENABLE = 3'd1;
   localparam logic [2:0] REG_CHANNELS    = 3'd2;
   localparam logic [2:0] REG_PIXELS      = 3'd3;
   localparam logic [2:0] REG_IMAGES      = 3'd4;

   localparam int CSR_DW = 21;

   // Input opcodes.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_PROCESS = 1'b1;

   // Coefficient word in the table memory: offset, mean, scale from the top.
   localparam int COEF_W = 48;

   typedef struct packed {
      logic        layout;
      logic        relu_enable;
      logic [6:0]  channel_count;
      logic [20:0] pixels_per_image;
      logic [15:0] image_count;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [15:0] scale;
      logic signed [15:0] mean;
      logic signed [15:0] offset;
      logic [5:0]         channel;
      logic               last;
   } entry_type;

endpackage

`default_nettype wire

/* rtl/batch_norm_relu_stream.sv */
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser opcode, tdata sample and coefficients
// rsp      out        rsp_tvalid/rsp_tready  tuser saturated, tlast last, tdata result
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle is accepted while the queue has room; a sample's result passes the
// read stage, the queue and the back stages and leaves at an edge with rsp_tready high.
// The coefficient memory is read once per sample in the front; the back runs subtract,
// multiply and add/saturate as three stages behind a four-item queue. Synchronous reset
// clears the counters, queue and pipeline and restores the configuration defaults. A
// stalled result holds the back; the front keeps taking items until the queue fills.
`default_nettype none

module batch_norm_relu_stream
   import bnr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic               req_tuser,  // [0] opcode
   // [15:0] sample_value, [21:16] coef_channel, [37:22] coef_scale,
   // [53:38] coef_mean, [69:54] coef_offset, [71:70] zero
   input  wire logic [71:0]        req_tdata,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic                    rsp_tuser,  // [0] saturated
   // [15:0] result_value, [21:16] result_channel, [23:22] zero
   output logic [23:0]             rsp_tdata,
   output logic                    rsp_tlast,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [CSR_DW-1:0]  csr_data
);

   cfg_type        cfg_ff, cfg_in;
   logic           push_valid;
   entry_type      push_entry;
   logic           pop;
   logic           q_valid;
   entry_type      q_entry;
   logic [QLW-1:0] q_level;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_LAYOUT:      cfg_in.layout           = csr_data[0];
            REG_RELU_ENABLE: cfg_in.relu_enable      = csr_data[0];
            REG_CHANNELS:    cfg_in.channel_count    = csr_data[6:0];
            REG_PIXELS:      cfg_in.pixels_per_image = csr_data[20:0];
            REG_IMAGES:      cfg_in.image_count      = csr_data[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout           <= 1'b0;
         cfg_ff.relu_enable      <= 1'b0;
         cfg_ff.channel_count    <= 7'd1;
         cfg_ff.pixels_per_image <= 21'd1;
         cfg_ff.image_count      <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bnr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_level    (q_level),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   bnr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .out_valid  (q_valid),
      .out_entry  (q_entry),
      .level      (q_level)
   );

   bnr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .relu_enable (cfg_ff.relu_enable),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/bnr_ram.sv */
`default_nettype none

module bnr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/bnr_front.sv */
`default_nettype none

module bnr_front
   import bnr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic              req_tuser,
   input  wire logic [71:0]       req_tdata,
   input  wire logic [QLW-1:0]    q_level,
   output logic                   push_valid,
   output entry_type              push_entry
);

   logic [CH_AW-1:0] ch_pos_ff, ch_pos_in;
   logic [20:0]      pix_pos_ff, pix_pos_in;
   logic [15:0]      img_pos_ff, img_pos_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_sample_ff;
   logic [5:0]  s1_channel_ff;
   logic        s1_last_ff;

   logic [31:0] nch, npix, nimg, cc;
   logic        wrap_c, wrap_p, wrap_i, last;
   logic [CH_AW-1:0] ch_step;
   logic [20:0]      pix_step;
   logic [15:0]      img_step;
   logic        accept, proc_acc, load_acc;
   logic [COEF_W-1:0] rd_data;
   logic [5:0]  coef_channel;

   // An item is taken only when the queue has room for it and the one in the read stage.
   assign req_tready = ({1'b0, q_level} + {{QLW{1'b0}}, s1_valid_ff}) < (QLW + 1)'(QDEPTH);
   assign accept   = req_tvalid && req_tready;
   assign proc_acc = accept && (req_tuser == OP_PROCESS);
   assign load_acc = accept && (req_tuser == OP_LOAD);
   assign coef_channel = req_tdata[21:16];

   always_comb begin
      cc = 32'(cfg.channel_count);
      if (cc == 32'd0) begin
         nch = 32'd1;
      end else if (cc > 32'(MAX_CHANNELS)) begin
         nch = 32'(MAX_CHANNELS);
      end else begin
         nch = cc;
      end
      npix = (cfg.pixels_per_image == 21'd0) ? 32'd1 : 32'(cfg.pixels_per_image);
      nimg = (cfg.image_count == 16'd0) ? 32'd1 : 32'(cfg.image_count);

      wrap_c = (32'(ch_pos_ff) + 32'd1) >= nch;
      wrap_p = (32'(pix_pos_ff) + 32'd1) >= npix;
      wrap_i = (32'(img_pos_ff) + 32'd1) >= nimg;
      last   = wrap_c && wrap_p && wrap_i;

      ch_step  = wrap_c ? '0 : ch_pos_ff + CH_AW'(1);
      pix_step = wrap_p ? '0 : pix_pos_ff + 21'd1;
      img_step = wrap_i ? '0 : img_pos_ff + 16'd1;

      ch_pos_in  = ch_pos_ff;
      pix_pos_in = pix_pos_ff;
      img_pos_in = img_pos_ff;
      if (proc_acc) begin
         if (last) begin
            ch_pos_in  = '0;
            pix_pos_in = '0;
            img_pos_in = '0;
         end else if (!cfg.layout) begin
            pix_pos_in = pix_step;
            if (wrap_p) begin
               ch_pos_in = ch_step;
               if (wrap_c) begin
                  img_pos_in = img_step;
               end
            end
         end else begin
            ch_pos_in = ch_step;
            if (wrap_c) begin
               pix_pos_in = pix_step;
               if (wrap_p) begin
                  img_pos_in = img_step;
               end
            end
         end
      end
      s1_valid_in = proc_acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_pos_ff   <= '0;
         pix_pos_ff  <= '0;
         img_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         ch_pos_ff   <= ch_pos_in;
         pix_pos_ff  <= pix_pos_in;
         img_pos_ff  <= img_pos_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_acc) begin
         s1_sample_ff  <= req_tdata[15:0];
         s1_channel_ff <= 6'(ch_pos_ff);
         s1_last_ff    <= last;
      end
   end

   bnr_ram #(
      .WIDTH(COEF_W),
      .DEPTH(MAX_CHANNELS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (load_acc && (32'(coef_channel) < 32'(MAX_CHANNELS))),
      .wr_addr (CH_AW'(coef_channel)),
      .wr_data (req_tdata[69:22]),
      .rd_en   (proc_acc),
      .rd_addr (ch_pos_ff),
      .rd_data (rd_data)
   );

   assign push_valid = s1_valid_ff;

   always_comb begin
      push_entry.sample  = s1_sample_ff;
      push_entry.scale   = rd_data[15:0];
      push_entry.mean    = rd_data[31:16];
      push_entry.offset  = rd_data[47:32];
      push_entry.channel = s1_channel_ff;
      push_entry.last    = s1_last_ff;
   end

endmodule

`default_nettype wire

/* rtl/bnr_queue.sv */
`default_nettype none

module bnr_queue
   import bnr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire entry_type      push_entry,
   input  wire logic           pop,
   output logic                out_valid,
   output entry_type           out_entry,
   output logic [QLW-1:0]      level
);

   entry_type          entries_ff [QDEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QLW-1:0]     level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QDEPTH - 1) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QDEPTH - 1) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + QLW'(1);
      end else if (pop && !push) begin
         level_in = level_ff - QLW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign out_valid = (level_ff != '0);
   assign out_entry = entries_ff[rd_ptr_ff];
   assign level     = level_ff;

endmodule

`default_nettype wire

/* rtl/bnr_back.sv */
`default_nettype none

module bnr_back
   import bnr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           relu_enable,
   input  wire logic           q_valid,
   input  wire entry_type      q_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic                rsp_tuser,
   output logic [23:0]         rsp_tdata,
   output logic                rsp_tlast
);

   logic advance;

   // Subtract stage.
   logic               a_valid_ff;
   logic signed [16:0] a_diff_ff;
   logic signed [15:0] a_scale_ff, a_offset_ff;
   logic [5:0]         a_channel_ff;
   logic               a_last_ff;

   // Multiply stage.
   logic               b_valid_ff;
   logic signed [32:0] b_prod_ff;
   logic signed [15:0] b_offset_ff;
   logic [5:0]         b_channel_ff;
   logic               b_last_ff;

   // Output register.
   logic               o_valid_ff;
   logic [15:0]        o_value_ff, o_value_in;
   logic [5:0]         o_channel_ff;
   logic               o_sat_ff, o_sat_in;
   logic               o_last_ff;

   logic signed [20:0] quot;
   logic signed [21:0] sum;

   // The whole back pipeline moves together whenever the output can take a new item.
   assign advance = !o_valid_ff || rsp_tready;
   assign pop     = advance && q_valid;

   always_comb begin
      quot = b_prod_ff[32:12];
      sum  = 22'(quot) + 22'(b_offset_ff);
      o_sat_in = 1'b0;
      if (relu_enable && sum[21]) begin
         o_value_in = 16'd0;
      end else if (sum > 22'sd32767) begin
         o_value_in = 16'h7FFF;
         o_sat_in   = 1'b1;
      end else if (sum < -22'sd32768) begin
         o_value_in = 16'h8000;
         o_sat_in   = 1'b1;
      end else begin
         o_value_in = sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= q_valid;
         b_valid_ff <= a_valid_ff;
         o_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_diff_ff    <= 17'(q_entry.sample) - 17'(q_entry.mean);
         a_scale_ff   <= q_entry.scale;
         a_offset_ff  <= q_entry.offset;
         a_channel_ff <= q_entry.channel;
         a_last_ff    <= q_entry.last;

         b_prod_ff    <= 33'(a_scale_ff) * 33'(a_diff_ff);
         b_offset_ff  <= a_offset_ff;
         b_channel_ff <= a_channel_ff;
         b_last_ff    <= a_last_ff;

         o_value_ff   <= o_value_in;
         o_sat_ff     <= o_sat_in;
         o_channel_ff <= b_channel_ff;
         o_last_ff    <= b_last_ff;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {2'b00, o_channel_ff, o_value_ff};
   assign rsp_tuser  = o_sat_ff;
   assign rsp_tlast  = o_last_ff;

endmodule

`default_nettype wire
